// ===== rtl/sh24_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sh24_pkg;

  // initialization constants
  localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
  localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
  localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
  localparam logic [63:0] SIP_C3 = 64'h7465646279746573;
  localparam logic [63:0] FIN_XOR = 64'h00000000000000ff;

  // key register reset values
  localparam logic [63:0] KEY_LOW_RESET  = 64'h0706050403020100;
  localparam logic [63:0] KEY_HIGH_RESET = 64'h0f0e0d0c0b0a0908;

  // register index as decoded from paddr[3]
  localparam logic REG_KEY_LOW  = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  typedef logic [3:0][63:0] lanes_t;

  // command kinds handed from front to core
  typedef enum logic [1:0] {
    CMD_ABSORB     = 2'd0,  // absorb a full word
    CMD_FINAL      = 2'd1,  // absorb partial word with length, finalize
    CMD_FULL_FINAL = 2'd2   // absorb full word, then length block, finalize
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [63:0] word;
    logic [7:0]  count;
  } cmd_t;

  // lanes loaded at message start
  function automatic lanes_t sip_init(input logic [63:0] k0, input logic [63:0] k1);
    lanes_t v;
    v[0] = SIP_C0 ^ k0;
    v[1] = SIP_C1 ^ k1;
    v[2] = SIP_C2 ^ k0;
    v[3] = SIP_C3 ^ k1;
    return v;
  endfunction

  // one sip round
  function automatic lanes_t sip_round(input lanes_t v);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
    lanes_t      r;
    a = v[0];
    b = v[1];
    c = v[2];
    d = v[3];
    a = a + b;
    b = {b[50:0], b[63:51]};
    b = b ^ a;
    a = {a[31:0], a[63:32]};
    c = c + d;
    d = {d[47:0], d[63:48]};
    d = d ^ c;
    a = a + d;
    d = {d[42:0], d[63:43]};
    d = d ^ a;
    c = c + b;
    b = {b[46:0], b[63:47]};
    b = b ^ c;
    c = {c[31:0], c[63:32]};
    r[0] = a;
    r[1] = b;
    r[2] = c;
    r[3] = d;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sh24_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sh24_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    in_data_byte,
  input  wire logic          in_byte_present,
  input  wire logic          in_last,
  output logic               msg_start,
  output logic               push,
  output sh24_pkg::cmd_t     push_cmd,
  input  wire logic          q_full
);
  import sh24_pkg::*;

  logic [63:0] buf_r, buf_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic        open_r, open_nxt;
  logic        accept;
  logic [63:0] merged;
  logic [7:0]  cnt_inc;
  logic        word_full;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // first word of a message that carries a byte or an end
  assign msg_start = accept && (in_byte_present || in_last) && !open_r;

  // drop the byte into its lane of the partial word
  always_comb begin
    merged = buf_r;
    for (int b = 0; b < 8; b++) begin
      if (cnt_r[2:0] == 3'(b)) begin
        merged[b*8 +: 8] = in_data_byte;
      end
    end
  end

  assign cnt_inc   = cnt_r + 8'd1;
  assign word_full = (cnt_inc[2:0] == 3'd0);

  // classify the word and build the core command
  always_comb begin
    buf_nxt        = buf_r;
    cnt_nxt        = cnt_r;
    open_nxt       = open_r;
    push           = 1'b0;
    push_cmd.kind  = CMD_ABSORB;
    push_cmd.word  = merged;
    push_cmd.count = cnt_inc;
    if (accept) begin
      if (in_byte_present || in_last) begin
        open_nxt = !in_last;
      end
      if (in_byte_present) begin
        if (word_full && !in_last) begin
          push    = 1'b1;
          buf_nxt = '0;
          cnt_nxt = cnt_inc;
        end else if (word_full) begin
          push          = 1'b1;
          push_cmd.kind = CMD_FULL_FINAL;
          buf_nxt       = '0;
          cnt_nxt       = '0;
        end else if (in_last) begin
          push          = 1'b1;
          push_cmd.kind = CMD_FINAL;
          buf_nxt       = '0;
          cnt_nxt       = '0;
        end else begin
          buf_nxt = merged;
          cnt_nxt = cnt_inc;
        end
      end else if (in_last) begin
        push           = 1'b1;
        push_cmd.kind  = CMD_FINAL;
        push_cmd.word  = buf_r;
        push_cmd.count = cnt_r;
        buf_nxt        = '0;
        cnt_nxt        = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r  <= '0;
      cnt_r  <= '0;
      open_r <= 1'b0;
    end else begin
      buf_r  <= buf_nxt;
      cnt_r  <= cnt_nxt;
      open_r <= open_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sh24_cmdq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sh24_cmdq #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire sh24_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               q_valid,
  output sh24_pkg::cmd_t     q_cmd
);
  import sh24_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          do_push;
  logic          do_pop;

  assign full    = (fill_r == CW'(DEPTH));
  assign q_valid = (fill_r != '0);
  assign q_cmd   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + CW'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sh24_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sh24_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [63:0]   key_low,
  input  wire logic [63:0]   key_high,
  input  wire logic          q_valid,
  input  wire sh24_pkg::cmd_t q_cmd,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [63:0]        out_hash_value
);
  import sh24_pkg::*;

  // round schedule: two rounds for the word, two for the length block,
  // then four finalization rounds
  localparam logic [2:0] STEP_WORD0 = 3'd0;
  localparam logic [2:0] STEP_WORD1 = 3'd1;
  localparam logic [2:0] STEP_LEN0  = 3'd2;
  localparam logic [2:0] STEP_LEN1  = 3'd3;
  localparam logic [2:0] STEP_FIN0  = 3'd4;
  localparam logic [2:0] STEP_FIN3  = 3'd7;

  cmd_t        cmd_r, cmd_nxt;
  logic        busy_r, busy_nxt;
  logic [2:0]  step_r, step_nxt;
  lanes_t      lanes_r, lanes_nxt;
  logic        fresh_r, fresh_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_hash_r, out_hash_nxt;

  lanes_t      v_pre;
  lanes_t      v_rnd;
  logic [63:0] len_word;
  logic [63:0] msg;
  logic        is_final;
  logic        last_step;
  logic        advance;

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

  assign is_final  = (cmd_r.kind != CMD_ABSORB);
  assign last_step = is_final ? (step_r == STEP_FIN3) : (step_r == STEP_WORD1);
  assign advance   = busy_r && !(last_step && is_final && out_valid_r && out_stall);
  assign pop       = !busy_r && q_valid;

  // final block: partial word only for a plain final, length on top
  assign len_word = ((cmd_r.kind == CMD_FINAL) ? cmd_r.word : 64'd0) |
                    {cmd_r.count, 56'd0};
  assign msg      = step_r[1] ? len_word : cmd_r.word;

  // one round per cycle, unless a held result stalls the last round, with the message folded in around it
  always_comb begin
    v_pre = lanes_r;
    if (step_r == STEP_WORD0 || step_r == STEP_LEN0) begin
      v_pre[3] = lanes_r[3] ^ msg;
    end
    if (step_r == STEP_FIN0) begin
      v_pre[2] = lanes_r[2] ^ FIN_XOR;
    end
    v_rnd = sip_round(v_pre);
    if (step_r == STEP_WORD1 || step_r == STEP_LEN1) begin
      v_rnd[0] = v_rnd[0] ^ msg;
    end
  end

  // sequencing, lane update and result register
  always_comb begin
    cmd_nxt       = cmd_r;
    busy_nxt      = busy_r;
    step_nxt      = step_r;
    lanes_nxt     = lanes_r;
    fresh_nxt     = fresh_r;
    out_valid_nxt = out_valid_r;
    out_hash_nxt  = out_hash_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (advance) begin
      lanes_nxt = v_rnd;
      step_nxt  = step_r + 3'd1;
      if (last_step) begin
        busy_nxt = 1'b0;
        if (is_final) begin
          fresh_nxt     = 1'b1;
          out_valid_nxt = 1'b1;
          out_hash_nxt  = v_rnd[0] ^ v_rnd[1] ^ v_rnd[2] ^ v_rnd[3];
        end
      end
    end
    if (pop) begin
      cmd_nxt  = q_cmd;
      busy_nxt = 1'b1;
      step_nxt = (q_cmd.kind == CMD_FINAL) ? STEP_LEN0 : STEP_WORD0;
      // first command of a message loads the lanes from its key
      if (fresh_r) begin
        lanes_nxt = sip_init(key_low, key_high);
        fresh_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= STEP_WORD0;
      fresh_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    lanes_r    <= lanes_nxt;
    out_hash_r <= out_hash_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/siphash_2_4_byte_stream.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  | ports                                          | dir
// ---------+------------------------------------------------+-----
// in       | in_valid, in_stall, in_data_byte,              | in
//          | in_byte_present, in_last                       |
// out      | out_valid, out_stall, out_hash_value           | out
// cfg      | psel, penable, pwrite, paddr, pwdata, prdata,  | apb
//          | pready (key_low at 0x0, key_high at 0x8)       |
//
// one byte is taken per cycle while the command queue has room; the front
// packs bytes and queues a command per full word or message end. the core
// loads each command and runs one sip round per cycle unless a held result
// stalls it. the input stalls only when the command queue fills: short
// messages back to back, or a held result.
// rst_n is synchronous; it clears the queue, the partial word and the
// sequencer and sets the key to its default. a stalled result holds the core.
module siphash_2_4_byte_stream #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_byte_present,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_hash_value,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  import sh24_pkg::*;

  logic [63:0] key_low_r;
  logic [63:0] key_high_r;
  logic [63:0] msg_key_low_r;
  logic [63:0] msg_key_high_r;
  logic        cfg_wr;
  logic        msg_start;
  logic        push;
  cmd_t        push_cmd;
  logic        q_full;
  logic        pop;
  logic        q_valid;
  cmd_t        q_cmd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= KEY_LOW_RESET;
      key_high_r <= KEY_HIGH_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3])
        REG_KEY_LOW:  key_low_r  <= pwdata;
        REG_KEY_HIGH: key_high_r <= pwdata;
        default:      key_low_r  <= key_low_r;
      endcase
    end
  end

  // key held from the start of the message being received
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_key_low_r  <= KEY_LOW_RESET;
      msg_key_high_r <= KEY_HIGH_RESET;
    end else if (msg_start) begin
      msg_key_low_r  <= key_low_r;
      msg_key_high_r <= key_high_r;
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[3])
      REG_KEY_LOW:  prdata = key_low_r;
      REG_KEY_HIGH: prdata = key_high_r;
      default:      prdata = '0;
    endcase
  end

  sh24_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_byte_present (in_byte_present),
    .in_last         (in_last),
    .msg_start       (msg_start),
    .push            (push),
    .push_cmd        (push_cmd),
    .q_full          (q_full)
  );

  sh24_cmdq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  sh24_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .key_low        (msg_key_low_r),
    .key_high       (msg_key_high_r),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value)
  );

endmodule

`default_nettype wire

// ===== sim/siphash_2_4_byte_stream_test.sv =====
`timescale 1ns / 1ps

module siphash_2_4_byte_stream_test;

  // sip constants and default key
  localparam logic [63:0] SIP_INIT0 = 64'h736f6d6570736575;
  localparam logic [63:0] SIP_INIT1 = 64'h646f72616e646f6d;
  localparam logic [63:0] SIP_INIT2 = 64'h6c7967656e657261;
  localparam logic [63:0] SIP_INIT3 = 64'h7465646279746573;
  localparam logic [63:0] KEY0_DEFAULT = 64'h0706050403020100;
  localparam logic [63:0] KEY1_DEFAULT = 64'h0f0e0d0c0b0a0908;
  localparam logic [63:0] ALL_ONES = 64'hffffffffffffffff;

  localparam logic [3:0] ADDR_KEY_LOW  = {sh24_pkg::REG_KEY_LOW, 3'b000};
  localparam logic [3:0] ADDR_KEY_HIGH = {sh24_pkg::REG_KEY_HIGH, 3'b000};

  localparam int WORDS_PER_PHASE = 235;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES = 400;

  typedef logic [3:0][63:0] lane_set_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        present;
    logic        last;
    logic        known;
    logic [63:0] digest;
  } script_row_t;

  // directed words; typed digests are the published vectors for the default key
  localparam int SCRIPT_LEN = 23;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, 64'h726fdb47dd0e0e31},
    '{8'h00, 1'b1, 1'b1, 1'b1, 64'h74f839c593dc67fd},
    '{8'h00, 1'b1, 1'b0, 1'b0, 64'h0},
    '{8'h01, 1'b1, 1'b0, 1'b0, 64'h0},
    '{8'h02, 1'b1, 1'b0, 1'b0, 64'h0},
    '{8'h03, 1'b1, 1'b0, 1'b0, 64'h0},
    '{8'h04, 1'b1, 1'b0, 1'b0, 64'h0},
    '{8'h05, 1'b1, 1'b0, 1'b0, 64'h0},
    '{8'h06, 1'b1, 1'b0, 1'b0, 64'h0},
    '{8'h07, 1'b1, 1'b0, 1'b0, 64'h0},
    '{8'h08, 1'b1, 1'b0, 1'b0, 64'h0},
    '{8'h09, 1'b1, 1'b0, 1'b0, 64'h0},
    '{8'h0a, 1'b1, 1'b0, 1'b0, 64'h0},
    '{8'h0b, 1'b1, 1'b0, 1'b0, 64'h0},
    '{8'h0c, 1'b1, 1'b0, 1'b0, 64'h0},
    '{8'h0d, 1'b1, 1'b0, 1'b0, 64'h0},
    '{8'h0e, 1'b1, 1'b1, 1'b1, 64'ha129ca6149be45e5},
    '{8'h5a, 1'b0, 1'b0, 1'b0, 64'h0},
    '{8'hff, 1'b1, 1'b0, 1'b0, 64'h0},
    '{8'ha5, 1'b0, 1'b0, 1'b0, 64'h0},
    '{8'h80, 1'b1, 1'b0, 1'b0, 64'h0},
    '{8'h33, 1'b0, 1'b1, 1'b0, 64'h0},
    '{8'hff, 1'b1, 1'b1, 1'b0, 64'h0}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_byte_present;
  logic        in_last;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_hash_value;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  siphash_2_4_byte_stream dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_byte_present(in_byte_present),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // digest predictor state
  logic [63:0] key0;
  logic [63:0] key1;
  lane_set_t   sip_v;
  logic [63:0] word_acc;
  logic [7:0]  len_mod;
  bit          msg_open;

  logic [63:0] hash_due[$];
  int          errors;
  int          words_sent;
  int          digests_seen;
  int          key_settings;
  int          tx_gap_pct;
  int          rx_gap_pct;
  logic        hold_start;
  bit          hold_done;
  int          hold_left;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [63:0] rol(input logic [63:0] x, input int r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic lane_set_t compress(input lane_set_t s);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
    lane_set_t   r;
    a = s[0];
    b = s[1];
    c = s[2];
    d = s[3];
    a = a + b; b = rol(b, 13); b = b ^ a; a = rol(a, 32);
    c = c + d; d = rol(d, 16); d = d ^ c;
    a = a + d; d = rol(d, 21); d = d ^ a;
    c = c + b; b = rol(b, 17); b = b ^ c; c = rol(c, 32);
    r[0] = a;
    r[1] = b;
    r[2] = c;
    r[3] = d;
    return r;
  endfunction

  function automatic lane_set_t fold_word(input lane_set_t s, input logic [63:0] m);
    lane_set_t r;
    r = s;
    r[3] = r[3] ^ m;
    r = compress(compress(r));
    r[0] = r[0] ^ m;
    return r;
  endfunction

  // advance the predictor by one accepted word
  task automatic hash_step(input logic [7:0] d, input logic p, input logic l,
                           output bit done, output logic [63:0] digest);
    done = 1'b0;
    digest = 64'h0;
    if (!p && !l) return;
    if (!msg_open) begin
      sip_v[0] = SIP_INIT0 ^ key0;
      sip_v[1] = SIP_INIT1 ^ key1;
      sip_v[2] = SIP_INIT2 ^ key0;
      sip_v[3] = SIP_INIT3 ^ key1;
      word_acc = 64'h0;
      len_mod = 8'h0;
      msg_open = 1'b1;
    end
    if (p) begin
      word_acc = word_acc | (64'(d) << (8 * len_mod[2:0]));
      len_mod = len_mod + 8'd1;
      if (len_mod[2:0] == 3'd0) begin
        sip_v = fold_word(sip_v, word_acc);
        word_acc = 64'h0;
      end
    end
    if (!l) return;
    // final block carries length mod 256 in its top byte
    sip_v = fold_word(sip_v, word_acc | {len_mod, 56'h0});
    sip_v[2] = sip_v[2] ^ 64'hff;
    repeat (4) sip_v = compress(sip_v);
    digest = sip_v[0] ^ sip_v[1] ^ sip_v[2] ^ sip_v[3];
    done = 1'b1;
    msg_open = 1'b0;
    word_acc = 64'h0;
    len_mod = 8'h0;
  endtask

  // offer one word, wait for it to be taken, record what it should produce
  task automatic send_word(input logic [7:0] d, input logic p, input logic l,
                           input logic known, input logic [63:0] typed_digest);
    bit          done;
    logic [63:0] digest;
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data_byte <= d;
    in_byte_present <= p;
    in_last <= l;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    hash_step(d, p, l, done, digest);
    if (done) hash_due.push_back(known ? typed_digest : digest);
    if (p || l) words_sent++;
  endtask

  // one random message, with idle noise and an occasional bare end
  task automatic send_message(input int len);
    bit bare_end;
    bare_end = (len == 0) || ($urandom_range(4) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) send_word(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, 64'h0);
      send_word(8'($urandom_range(255)), 1'b1, !bare_end && (i == len - 1), 1'b0, 64'h0);
    end
    if (bare_end) send_word(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, 64'h0);
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(16);
    if (r < 92) return $urandom_range(64, 17);
    return $urandom_range(120, 65);
  endfunction

  // apb transfer: setup cycle, then access until pready
  task automatic apb_xfer(input logic [3:0] addr, input logic wr, input logic [63:0] wdata,
                          output logic [63:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // write both key halves and read them back
  task automatic set_keys(input logic [63:0] k0, input logic [63:0] k1);
    logic [63:0] rd;
    apb_xfer(ADDR_KEY_LOW, 1'b1, k0, rd);
    key0 = k0;
    apb_xfer(ADDR_KEY_HIGH, 1'b1, k1, rd);
    key1 = k1;
    apb_xfer(ADDR_KEY_LOW, 1'b0, 64'h0, rd);
    if (rd !== k0) begin
      $display("%0t: key_low readback expected %h actual %h", $time, k0, rd);
      errors++;
    end
    apb_xfer(ADDR_KEY_HIGH, 1'b0, 64'h0, rd);
    if (rd !== k1) begin
      $display("%0t: key_high readback expected %h actual %h", $time, k1, rd);
      errors++;
    end
    key_settings++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (hash_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side: check digests, random stalls, one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        digests_seen++;
        if (hash_due.size() == 0) begin
          $display("%0t: digest expected none actual %h", $time, out_hash_value);
          errors++;
        end else begin
          logic [63:0] want;
          want = hash_due.pop_front();
          if (out_hash_value !== want) begin
            $display("%0t: digest expected %h actual %h", $time, want, out_hash_value);
            errors++;
          end
        end
      end
      if (hold_start && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < rx_gap_pct);
      if (hold_left != 0) hold_left--;
    end
  end

  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    logic [63:0] k0;
    logic [63:0] k1;
    errors = 0;
    words_sent = 0;
    digests_seen = 0;
    key_settings = 0;
    hold_done = 1'b0;
    hold_left = 0;
    tx_gap_pct = 32;
    rx_gap_pct = 74;
    key0 = KEY0_DEFAULT;
    key1 = KEY1_DEFAULT;
    msg_open = 1'b0;
    word_acc = 64'h0;
    len_mod = 8'h0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data_byte <= 8'h0;
    in_byte_present <= 1'b0;
    in_last <= 1'b0;
    hold_start <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= 4'h0;
    pwdata <= 64'h0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < 6; ph++) begin
      tx_gap_pct = (ph < 2) ? 32 : (ph < 4) ? 74 : 0;
      rx_gap_pct = (ph < 2) ? 74 : (ph < 4) ? 32 : 0;
      if (ph == 0) begin
        // directed words under the default key
        for (int i = 0; i < SCRIPT_LEN; i++) begin
          send_word(SCRIPT[i].data, SCRIPT[i].present, SCRIPT[i].last,
                    SCRIPT[i].known, SCRIPT[i].digest);
        end
      end else begin
        drain();
        case (ph)
          1: begin
            k0 = 64'h0;
            k1 = 64'h0;
          end
          2: begin
            k0 = ALL_ONES;
            k1 = ALL_ONES;
          end
          4: begin
            k0 = 64'h0;
            k1 = ALL_ONES;
          end
          default: begin
            k0 = {$urandom, $urandom};
            k1 = {$urandom, $urandom};
          end
        endcase
        set_keys(k0, k1);
      end
      // receiver holds off while short messages keep coming
      if (ph == 4) hold_start <= 1'b1;
      // one message of 256 bytes or more so the length wraps
      if (ph == 2 || ph == 5) send_message($urandom_range(300, 256));
      while (words_sent < (ph + 1) * WORDS_PER_PHASE) send_message(pick_len());
    end

    drain();
    $display("sent %0d message words under %0d key settings plus the default key",
             words_sent, key_settings);
    $display("checked %0d digests, %0d mismatches", digests_seen, errors);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
